>>> design/gpmd_pkg.sv
package gpmd_pkg;

   localparam int OPND_W          = 32;
   localparam int RES_W           = 2 * OPND_W - 1;
   localparam int SHIFT_W         = $clog2(OPND_W);
   localparam int DEFAULT_WIDTH   = 32;
   localparam int STEPS_PER_STAGE = 4;

   typedef logic [OPND_W-1:0] opnd_type;
   typedef logic [RES_W-1:0]  res_type;

   localparam logic CMD_MUL = 1'b0;
   localparam logic CMD_DIV = 1'b1;

   // Working set carried down the pipeline
   typedef struct packed {
      logic               cmd;
      logic               dz;
      opnd_type           a;
      opnd_type           b;
      opnd_type           bn;
      logic [SHIFT_W-1:0] shift;
      opnd_type           rem;
      opnd_type           quo;
      res_type            prod;
   } stage_type;

endpackage

>>> design/gpmd_if.sv
interface gpmd_req_if;
   import gpmd_pkg::*;

   logic     valid;
   logic     ready;
   logic     cmd;
   opnd_type operand_a;
   opnd_type operand_b;

   modport source (output valid, cmd, operand_a, operand_b, input ready);
   modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface gpmd_rsp_if;
   import gpmd_pkg::*;

   logic     valid;
   logic     ready;
   res_type  main_result;
   opnd_type remainder;
   logic     divide_by_zero;

   modport source (output valid, main_result, remainder, divide_by_zero, input ready);
   modport sink   (input valid, main_result, remainder, divide_by_zero, output ready);
endinterface

>>> design/gf2_poly_mul_div_unit.sv
// Carry-less multiply and polynomial divide over GF(2).
//
// req_chan carries one beat per operand pair: cmd (multiply or divide),
// operand_a and operand_b; bits at and above WIDTH are ignored.
// rsp_chan returns exactly one beat per request, in order: main_result
// (product, or quotient in the low bits), remainder and divide_by_zero.
//
// Throughput: one beat per cycle while the receiver does not stall. Each
// request beat passes through the step pipeline: an entry stage finds the
// divisor degree and left-aligns the divisor, then each following stage
// does four shift-and-XOR steps of both the long division and the
// carry-less product.
//
// A zero divisor raises divide_by_zero and returns quotient 0 with the
// dividend as remainder.
//
// Reset empties every stage; payload registers are not cleared. When the
// receiver stalls, each stage holds its beat and only free stages advance,
// so request ready drops once the whole pipeline is full.
module gf2_poly_mul_div_unit #(
   parameter int WIDTH = gpmd_pkg::DEFAULT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   gpmd_req_if.sink          req_chan,
   gpmd_rsp_if.source        rsp_chan
);
   import gpmd_pkg::*;

   localparam int NUM_STAGES = (WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam opnd_type OPND_MASK = OPND_W'((64'd1 << WIDTH) - 64'd1);

   stage_type stage_ff [0:NUM_STAGES];
   stage_type stage_in [0:NUM_STAGES];
   logic      vld_ff   [0:NUM_STAGES];
   logic      adv      [0:NUM_STAGES+1];

   // Ready chain: a stage may take a beat when empty or when it moves on
   assign adv[NUM_STAGES+1] = rsp_chan.ready;
   for (genvar j = NUM_STAGES; j >= 0; j--) begin : g_adv
      assign adv[j] = !vld_ff[j] || adv[j+1];
   end
   assign req_chan.ready = adv[0];

   // Entry stage: mask operands, find divisor degree, left-align divisor
   always_comb begin : entry_comb
      opnd_type           a_m;
      opnd_type           b_m;
      logic [SHIFT_W-1:0] deg;
      a_m = req_chan.operand_a & OPND_MASK;
      b_m = req_chan.operand_b & OPND_MASK;
      deg = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (b_m[i]) begin
            deg = SHIFT_W'(i);
         end
      end
      stage_in[0].cmd   = req_chan.cmd;
      stage_in[0].dz    = (req_chan.cmd == CMD_DIV) && (b_m == '0);
      stage_in[0].a     = a_m;
      stage_in[0].b     = b_m;
      stage_in[0].shift = SHIFT_W'(WIDTH - 1) - deg;
      stage_in[0].bn    = b_m << stage_in[0].shift;
      stage_in[0].rem   = a_m;
      stage_in[0].quo   = '0;
      stage_in[0].prod  = '0;
   end

   // Step stages: four division and product steps each
   for (genvar j = 1; j <= NUM_STAGES; j++) begin : g_step
      always_comb begin : step_comb
         stage_type          p;
         logic [SHIFT_W:0]   k_idx;
         logic               qbit;
         p = stage_ff[j-1];
         qbit = 1'b0;
         for (int l = 0; l < STEPS_PER_STAGE; l++) begin
            k_idx = (SHIFT_W + 1)'((j - 1) * STEPS_PER_STAGE + l);
            if ((j - 1) * STEPS_PER_STAGE + l < WIDTH) begin
               // product: fold in the shifted multiplier for each set bit
               if (p.a[(j - 1) * STEPS_PER_STAGE + l]) begin
                  p.prod = p.prod ^ (RES_W'(p.b) << ((j - 1) * STEPS_PER_STAGE + l));
               end
               // division: steps run while the position is at or above the divisor degree
               if ({1'b0, p.shift} >= k_idx) begin
                  qbit = p.rem[WIDTH - 1 - ((j - 1) * STEPS_PER_STAGE + l)];
                  if (qbit) begin
                     p.rem = p.rem ^ (p.bn >> ((j - 1) * STEPS_PER_STAGE + l));
                  end
                  p.quo = {p.quo[OPND_W-2:0], qbit};
               end
            end
         end
         stage_in[j] = p;
      end
   end

   // Stage registers: advance where the ready chain allows, else hold
   always_ff @(posedge clock) begin
      for (int j = 0; j <= NUM_STAGES; j++) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            vld_ff[j] <= (j == 0) ? req_chan.valid : vld_ff[(j == 0) ? 0 : j - 1];
         end
         if (adv[j]) begin
            stage_ff[j] <= stage_in[j];
         end
      end
   end

   // Response formatting from the last stage
   always_comb begin
      rsp_chan.valid = vld_ff[NUM_STAGES];
      if (stage_ff[NUM_STAGES].cmd == CMD_MUL) begin
         rsp_chan.main_result    = stage_ff[NUM_STAGES].prod;
         rsp_chan.remainder      = '0;
         rsp_chan.divide_by_zero = 1'b0;
      end else if (stage_ff[NUM_STAGES].dz) begin
         rsp_chan.main_result    = '0;
         rsp_chan.remainder      = stage_ff[NUM_STAGES].a;
         rsp_chan.divide_by_zero = 1'b1;
      end else begin
         rsp_chan.main_result    = RES_W'(stage_ff[NUM_STAGES].quo);
         rsp_chan.remainder      = stage_ff[NUM_STAGES].rem;
         rsp_chan.divide_by_zero = 1'b0;
      end
   end

endmodule

>>> design/gpmd_checker.sv
module gpmd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input gpmd_pkg::res_type     rsp_main_result,
   input gpmd_pkg::opnd_type    rsp_remainder,
   input logic                  rsp_divide_by_zero
);
   import gpmd_pkg::*;

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_main_result)
         && $stable(rsp_remainder) && $stable(rsp_divide_by_zero))
      else $error("stalled response changed");

   // Zero divisor gives zero quotient
   a_dz_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_main_result == '0)
      else $error("nonzero quotient on zero divisor");

   // Only a product reaches the upper half; a product has no remainder
   a_wide_is_product: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_main_result[RES_W-1:OPND_W] != '0)
         |-> rsp_remainder == '0 && !rsp_divide_by_zero)
      else $error("wide result with remainder or divide flag");

endmodule

bind gf2_poly_mul_div_unit gpmd_checker u_gpmd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_main_result    (rsp_chan.main_result),
   .rsp_remainder      (rsp_chan.remainder),
   .rsp_divide_by_zero (rsp_chan.divide_by_zero)
);

>>> tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gpmd_pkg::*;

   // One response beat as the block should produce it
   typedef struct packed {
      res_type  main_result;
      opnd_type remainder;
      logic     divide_by_zero;
   } gf2_result_type;

   // One directed request; typed rows carry their answer, the rest are predicted
   typedef struct packed {
      logic           cmd;
      opnd_type       a;
      opnd_type       b;
      logic           typed;
      gf2_result_type want;
   } stim_row_type;

   localparam gf2_result_type NO_RES = '0;
   localparam int N_DIRECTED = 23;
   localparam int N_RANDOM_PER_PHASE = 234;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 20;

   // Directed rows: operand extremes, both commands, and the corner cases of
   // division (zero divisor, zero dividend, divisor of higher degree than the
   // dividend, equal degrees, division by one).
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{CMD_MUL, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{63'h0, 32'h0, 1'b0}},
      '{CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{63'h0, 32'h0, 1'b0}},
      '{CMD_MUL, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{63'hFFFF_FFFF, 32'h0, 1'b0}},
      '{CMD_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1,
        '{63'h4000_0000_0000_0000, 32'h0, 1'b0}},
      '{CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RES},
      '{CMD_MUL, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, NO_RES},
      '{CMD_MUL, 32'h0000_0003, 32'h0000_0003, 1'b1, '{63'h5, 32'h0, 1'b0}},
      '{CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{63'h0, 32'hFFFF_FFFF, 1'b1}},
      '{CMD_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, '{63'h0, 32'h0, 1'b1}},
      '{CMD_DIV, 32'h1234_5678, 32'h0000_0000, 1'b1, '{63'h0, 32'h1234_5678, 1'b1}},
      '{CMD_DIV, 32'h0000_0000, 32'h0000_0005, 1'b1, '{63'h0, 32'h0, 1'b0}},
      '{CMD_DIV, 32'h0000_0005, 32'h8000_0000, 1'b1, '{63'h0, 32'h5, 1'b0}},
      '{CMD_DIV, 32'h0000_FFFF, 32'h0001_0000, 1'b1, '{63'h0, 32'hFFFF, 1'b0}},
      '{CMD_DIV, 32'h8000_0000, 32'h8000_0000, 1'b1, '{63'h1, 32'h0, 1'b0}},
      '{CMD_DIV, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{63'h1, 32'h7FFF_FFFF, 1'b0}},
      '{CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{63'hFFFF_FFFF, 32'h0, 1'b0}},
      '{CMD_DIV, 32'h8000_0000, 32'h0000_0001, 1'b1, '{63'h8000_0000, 32'h0, 1'b0}},
      '{CMD_DIV, 32'h0000_0001, 32'h0000_0001, 1'b1, '{63'h1, 32'h0, 1'b0}},
      '{CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{63'h1, 32'h0, 1'b0}},
      '{CMD_DIV, 32'h0000_0005, 32'h0000_0003, 1'b1, '{63'h3, 32'h0, 1'b0}},
      '{CMD_DIV, 32'hDEAD_BEEF, 32'h0000_0007, 1'b0, NO_RES},
      '{CMD_DIV, 32'h8000_0000, 32'h0000_0003, 1'b0, NO_RES},
      '{CMD_MUL, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, NO_RES}
   };

   logic clock;
   logic reset;

   gpmd_req_if req_chan ();
   gpmd_rsp_if rsp_chan ();

   gf2_poly_mul_div_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Results still owed by the block, oldest first
   gf2_result_type pending_results[$];
   gf2_result_type oldest_result;
   int             mismatches;

   // Traffic phase: 0 = light sender gaps, heavy receiver stalls;
   // 1 = the other way round; 2 = both sides flat out
   int             phase;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Carry-less product, or long division by XOR comparing degrees
   function automatic gf2_result_type gf2_compute(logic cmd, opnd_type a, opnd_type b);
      gf2_result_type r;
      res_type        prod;
      opnd_type       quo;
      opnd_type       rem;
      int             db;
      r = '0;
      if (cmd == CMD_MUL) begin
         prod = '0;
         for (int i = 0; i < OPND_W; i++) begin
            if (a[i]) prod ^= res_type'(b) << i;
         end
         r.main_result = prod;
      end else if (b == '0) begin
         // zero divisor: flag it, quotient 0, dividend passes through
         r.divide_by_zero = 1'b1;
         r.remainder = a;
      end else begin
         db = 0;
         for (int i = 0; i < OPND_W; i++) begin
            if (b[i]) db = i;
         end
         quo = '0;
         rem = a;
         for (int i = OPND_W - 1; i >= db; i--) begin
            if (rem[i]) begin
               rem ^= b << (i - db);
               quo[i - db] = 1'b1;
            end
         end
         r.main_result = res_type'(quo);
         r.remainder = rem;
      end
      return r;
   endfunction

   // Polynomial of exactly the given degree with random lower terms; -1 gives zero
   function automatic opnd_type poly_of_degree(int deg);
      opnd_type v;
      if (deg < 0) return '0;
      v = $urandom;
      if (deg < OPND_W - 1) v &= (opnd_type'(1) << (deg + 1)) - opnd_type'(1);
      v[deg] = 1'b1;
      return v;
   endfunction

   // Bias towards zero, full degree and tiny degrees
   function automatic int pick_degree();
      int r;
      r = $urandom_range(99);
      if (r < 6) return -1;
      if (r < 20) return OPND_W - 1;
      if (r < 35) return $urandom_range(3);
      return $urandom_range(OPND_W - 1);
   endfunction

   function automatic int sender_idle_pct();
      case (phase)
         0: return 10;
         1: return 56;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (phase)
         0: return 56;
         1: return 10;
         default: return 0;
      endcase
   endfunction

   // Offer one request beat. Entered and left on a falling edge; valid stays
   // high across back-to-back beats so it is never lowered and raised in one step.
   task automatic send_beat(logic cmd, opnd_type a, opnd_type b, gf2_result_type want);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      forever begin
         @(posedge clock);
         if (req_chan.ready) break;
      end
      pending_results.push_back(want);
      @(negedge clock);
   endtask

   // Mostly shaped operands so that degree relations get hit often, with a
   // share of fully random words so every bit toggles
   task automatic send_random_beat();
      logic     cmd;
      opnd_type a;
      opnd_type b;
      int       da;
      cmd = $urandom_range(1) ? CMD_DIV : CMD_MUL;
      if ($urandom_range(4) == 0) begin
         a = $urandom;
         b = $urandom;
      end else begin
         da = pick_degree();
         a = poly_of_degree(da);
         // now and then force equal degrees so exactly one reduction step fires
         b = poly_of_degree(($urandom_range(4) == 0) ? da : pick_degree());
      end
      send_beat(cmd, a, b, gf2_compute(cmd, a, b));
   endtask

   // Receiver: random back-pressure per phase, plus one long hold once both
   // sides go flat out, so the pipeline fills and request ready drops
   initial begin
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && phase == 2) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct());
         end
      end
   end

   // Compare each response beat against the oldest outstanding result
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("response beat with nothing outstanding: main_result %h",
                   rsp_chan.main_result);
            mismatches++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_chan.main_result !== oldest_result.main_result) begin
               $error("main_result: expected %h, got %h",
                      oldest_result.main_result, rsp_chan.main_result);
               mismatches++;
            end
            if (rsp_chan.remainder !== oldest_result.remainder) begin
               $error("remainder: expected %h, got %h",
                      oldest_result.remainder, rsp_chan.remainder);
               mismatches++;
            end
            if (rsp_chan.divide_by_zero !== oldest_result.divide_by_zero) begin
               $error("divide_by_zero: expected %b, got %b",
                      oldest_result.divide_by_zero, rsp_chan.divide_by_zero);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #400_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      mismatches = 0;
      phase = 0;
      reset <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= CMD_MUL;
      req_chan.operand_a <= '0;
      req_chan.operand_b <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows first; typed answers where obvious, predictor elsewhere
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_beat(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
                   DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].want :
                   gf2_compute(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].a,
                               DIRECTED_ROWS[i].b));
      end

      // Random traffic across the three traffic phases
      for (int p = 0; p < 3; p++) begin
         phase = p;
         repeat (N_RANDOM_PER_PHASE) send_random_beat();
      end
      req_chan.valid <= 1'b0;

      // Drain, then linger a little to catch stray beats
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
